>>> hw/rtl/msad_pkg.sv
// Shared types, bit positions and constants for the Mode S altitude decoder.
// No dependencies; compile first.
`timescale 1ns / 1ps

package msad_pkg;

    localparam int unsigned CODE_W = 13;
    localparam int unsigned FEET_W = 18;

    // Bit positions inside the altitude code
    localparam int unsigned M_BIT = 6;
    localparam int unsigned Q_BIT = 4;

    // Fixed scale and offset values, in feet
    localparam logic [FEET_W-1:0] Q_STEP_FT      = 18'd25;
    localparam logic [FEET_W-1:0] Q_OFFSET_FT    = 18'd1000;
    localparam logic [FEET_W-1:0] G_STEP_FT      = 18'd500;
    localparam logic [FEET_W-1:0] C_STEP_FT      = 18'd100;
    localparam logic [FEET_W-1:0] GILL_OFFSET_FT = 18'd1300;

    localparam logic [2:0] C_ILLEGAL = 3'd7;
    localparam logic [2:0] C_SUBST   = 3'd5;
    localparam logic [2:0] C_MIRROR  = 3'd6;

    typedef struct packed {
        logic [CODE_W-1:0] alt_code;
        logic              thirteen_bit_form;
    } t_in_req;

    typedef struct packed {
        logic signed [FEET_W-1:0] altitude_ft;
        logic                     metric_rejected;
    } t_out_req;

    // Gray to binary: each binary bit is the XOR of its own Gray bit and all Gray bits above it
    function automatic logic [7:0] gray8_to_bin(input logic [7:0] g);
        logic [7:0] b;
        b[7] = g[7];
        for (int i = 6; i >= 0; i--) begin
            b[i] = b[i+1] ^ g[i];
        end
        return b;
    endfunction

    function automatic logic [2:0] gray3_to_bin(input logic [2:0] g);
        logic [2:0] b;
        b[2] = g[2];
        b[1] = g[2] ^ g[1];
        b[0] = g[2] ^ g[1] ^ g[0];
        return b;
    endfunction

endpackage

>>> hw/rtl/msad_if.sv
// Valid/ready channel interfaces for code requests and altitude results.
// Depends on msad_pkg for the payload types.
`timescale 1ns / 1ps

interface msad_in_if;
    import msad_pkg::*;
    logic    valid;
    logic    ready;
    t_in_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface msad_out_if;
    import msad_pkg::*;
    logic     valid;
    logic     ready;
    t_out_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/mode_s_altitude_decode.sv
// Mode S altitude decoder top level: input register, decode logic, result register.
// Depends on msad_pkg and the channel interfaces in msad_if.sv.
`timescale 1ns / 1ps

// Decodes a Mode S altitude code into feet. Each request carries the raw code
// and a flag that picks the 13-bit AC layout (with M bit) or the 12-bit ADS-B
// layout. Every request gives exactly one result, in order. With M set in the
// 13-bit layout the result is -1 with metric_rejected high. With Q set the
// remaining bits form a count N and the altitude is N*25 - 1000. With Q clear
// the bits are read as a Gillham code: 500-foot Gray steps from D, A and B,
// 100-foot steps from C (7 read as 5, mirrored on odd 500-foot counts), minus
// 1300. Throughput is one request per clock while o_rsp is not stalled. The input
// register loads on accept, and the result register loads from it once the result
// stage is free. The input stage can fill while the result stage is stalled, and
// a new request is taken whenever the input stage is empty or can move into the
// result stage. No reset sweep is needed.
module mode_s_altitude_decode
    import msad_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    msad_in_if.sink     i_req,
    msad_out_if.source  o_rsp
);

    logic     r_in_valid;
    t_in_req  r_in;
    logic     r_out_valid;
    t_out_req r_out;

    logic     out_free;
    logic     in_free;
    t_out_req n_out;

    // Result stage frees up when empty or being drained this cycle
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign in_free     = !r_in_valid || out_free;
    assign i_req.ready = in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_req.valid;
        end
        if (in_free && i_req.valid) begin
            r_in <= i_req.payload;
        end
    end

    // Decode datapath
    logic [CODE_W-1:0] code;
    logic              form13;
    logic [CODE_W-1:0] gcode;
    logic [11:0]       q_count;
    logic [7:0]        g_gray;
    logic [7:0]        g_bin;
    logic [2:0]        c_bin;
    logic [2:0]        c_fix;
    logic [2:0]        c_val;
    logic [FEET_W-1:0] q_feet;
    logic [FEET_W-1:0] g_feet;

    always_comb begin
        code   = r_in.alt_code;
        form13 = r_in.thirteen_bit_form;

        // Q path count: drop Q (and M in 13-bit form)
        if (form13) begin
            q_count = {1'b0, code[12:7], code[5], code[3:0]};
        end else begin
            q_count = {code[12:5], code[3:0]};
        end
        q_feet = FEET_W'(q_count) * Q_STEP_FT - Q_OFFSET_FT;

        // Gillham path: open a slot for M in the 12-bit layout
        if (form13) begin
            gcode = code;
        end else begin
            gcode = {code[11:6], 1'b0, code[5:0]};
        end

        // D2 D4 A1 A2 A4 B1 B2 B4, MSB first
        g_gray = {gcode[2], gcode[0], gcode[11], gcode[9],
                  gcode[7], gcode[5], gcode[3], gcode[1]};
        g_bin  = gray8_to_bin(g_gray);

        // C1 C2 C4, MSB first; illegal seven reads as five
        c_bin = gray3_to_bin({gcode[12], gcode[10], gcode[8]});
        c_fix = (c_bin == C_ILLEGAL) ? C_SUBST : c_bin;
        c_val = g_bin[0] ? (C_MIRROR - c_fix) : c_fix;

        g_feet = FEET_W'(g_bin) * G_STEP_FT + FEET_W'(c_val) * C_STEP_FT
                 - GILL_OFFSET_FT;

        priority if (form13 && code[M_BIT]) begin
            n_out.altitude_ft     = -18'sd1;
            n_out.metric_rejected = 1'b1;
        end else if (code[Q_BIT]) begin
            n_out.altitude_ft     = $signed(q_feet);
            n_out.metric_rejected = 1'b0;
        end else begin
            n_out.altitude_ft     = $signed(g_feet);
            n_out.metric_rejected = 1'b0;
        end
    end

    // Result register: load when free, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (out_free && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

endmodule
